// ===== rtl/srxf_pkg.sv =====
// Shared constants, command and status types for the serial receive ring buffer.
`timescale 1ns / 1ps

package srxf_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int NEST_W = 4;
  localparam logic [NEST_W-1:0] NEST_MAX = 4'd15;

  localparam logic [7:0] FLOW_XOFF = 8'h13;
  localparam logic [7:0] FLOW_XON  = 8'h11;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_DRAIN  = 2'd1;
  localparam logic [1:0] KIND_PAUSE  = 2'd2;
  localparam logic [1:0] KIND_RESUME = 2'd3;

  localparam logic [1:0] LINE_OK = 2'd0;

  localparam logic OUT_CHAR = 1'b0;
  localparam logic OUT_FLOW = 1'b1;

  // Configuration register word indexes
  localparam logic [1:0] REG_LINK  = 2'd0;
  localparam logic [1:0] REG_FLUSH = 2'd1;
  localparam logic [1:0] REG_PAUSE = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // latch the incoming byte
    logic wr_en;      // store a byte at the write index
    logic wr_latched; // store the latched byte rather than the live input
    logic rd_en;      // read the oldest byte out and advance
    logic rd_last;    // that byte ends the transaction's results
    logic depth_inc;
    logic depth_dec;
    logic flow_emit;  // send a flow control byte
    logic flow_xon;   // 1 XON, 0 XOFF
    logic flow_last;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic rd_is_last; // one byte left in the ring
    logic depth_zero;
    logic depth_one;
    logic depth_max;
  } stat_t;

  function automatic idx_t idx_next(idx_t i);
    idx_t r;
    if (i == idx_t'(DEPTH - 1)) r = '0;
    else r = i + idx_t'(1);
    return r;
  endfunction

endpackage

// ===== rtl/srxf_ctrl.sv =====
// Controller state machine: decodes transactions and sequences drains.
`timescale 1ns / 1ps

module srxf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     kind,
  input  logic [1:0]     rx_status,
  input  logic           link_connected,
  input  logic           flush_when_full,
  input  logic           pause_during_drain,
  input  srxf_pkg::stat_t stat,
  output srxf_pkg::cmd_t  cmd,
  output logic           busy
);
  import srxf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DRAIN,
    S_RESUME
  } state_t;

  state_t state, state_next;
  logic   wrap, wrap_next;   // drain is wrapped by XOFF/XON
  logic   store, store_next; // store the latched byte after the drain

  always_comb begin
    cmd        = '0;
    state_next = state;
    wrap_next  = wrap;
    store_next = store;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          case (kind)
            KIND_BYTE: begin
              if (link_connected && rx_status == LINE_OK) begin
                if (!stat.full) begin
                  cmd.wr_en = 1'b1;
                end else if (flush_when_full) begin
                  wrap_next     = pause_during_drain && link_connected && stat.depth_zero;
                  store_next    = 1'b1;
                  cmd.flow_emit = wrap_next;
                  state_next    = S_DRAIN;
                end
              end
            end
            KIND_DRAIN: begin
              if (!stat.empty) begin
                wrap_next     = pause_during_drain && link_connected && stat.depth_zero;
                store_next    = 1'b0;
                cmd.flow_emit = wrap_next;
                state_next    = S_DRAIN;
              end
            end
            KIND_PAUSE: begin
              if (!stat.depth_max) begin
                cmd.depth_inc = 1'b1;
                cmd.flow_emit = link_connected && stat.depth_zero;
                cmd.flow_last = 1'b1;
              end
            end
            KIND_RESUME: begin
              if (!stat.depth_zero) begin
                cmd.depth_dec = 1'b1;
                cmd.flow_emit = link_connected && stat.depth_one;
                cmd.flow_xon  = 1'b1;
                cmd.flow_last = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_DRAIN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_last = stat.rd_is_last && !wrap;
        if (stat.rd_is_last) begin
          cmd.wr_en      = store;
          cmd.wr_latched = 1'b1;
          state_next     = wrap ? S_RESUME : S_IDLE;
        end
      end
      S_RESUME: begin
        cmd.flow_emit = 1'b1;
        cmd.flow_xon  = 1'b1;
        cmd.flow_last = 1'b1;
        state_next    = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wrap  <= 1'b0;
      store <= 1'b0;
    end else begin
      state <= state_next;
      wrap  <= wrap_next;
      store <= store_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== rtl/srxf_dp.sv =====
// Datapath: character ring, indices, pause nesting counter and result registers.
`timescale 1ns / 1ps

module srxf_dp (
  input  logic            clk,
  input  logic            rst,
  input  srxf_pkg::cmd_t  cmd,
  input  logic [7:0]      rx_byte,
  output srxf_pkg::stat_t stat,
  output logic            out_strobe,
  output logic            out_kind,
  output logic [7:0]      out_byte,
  output logic            last
);
  import srxf_pkg::*;

  logic [7:0]        mem [DEPTH];
  idx_t              rd_idx, wr_idx;
  logic [NEST_W-1:0] depth;
  logic [7:0]        byte_q;
  logic [7:0]        mem_q;
  logic              char_pend, char_last;
  logic              flow_pend, flow_last;
  logic [7:0]        flow_byte;

  always_comb begin
    stat.empty      = (rd_idx == wr_idx);
    stat.full       = (idx_next(wr_idx) == rd_idx);
    stat.rd_is_last = (idx_next(rd_idx) == wr_idx);
    stat.depth_zero = (depth == '0);
    stat.depth_one  = (depth == NEST_W'(1));
    stat.depth_max  = (depth == NEST_MAX);
  end

  // Ring storage, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_idx] <= cmd.wr_latched ? byte_q : rx_byte;
    if (cmd.rd_en) mem_q <= mem[rd_idx];
    if (cmd.capture) byte_q <= rx_byte;
    if (cmd.rd_en) char_last <= cmd.rd_last;
    if (cmd.flow_emit) begin
      flow_byte <= cmd.flow_xon ? FLOW_XON : FLOW_XOFF;
      flow_last <= cmd.flow_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      wr_idx    <= '0;
      depth     <= '0;
      char_pend <= 1'b0;
      flow_pend <= 1'b0;
    end else begin
      if (cmd.rd_en) rd_idx <= idx_next(rd_idx);
      if (cmd.wr_en) wr_idx <= idx_next(wr_idx);
      if (cmd.depth_inc) depth <= depth + NEST_W'(1);
      else if (cmd.depth_dec) depth <= depth - NEST_W'(1);
      char_pend <= cmd.rd_en;
      flow_pend <= cmd.flow_emit;
    end
  end

  assign out_strobe = char_pend | flow_pend;
  assign out_kind   = flow_pend ? OUT_FLOW : OUT_CHAR;
  assign out_byte   = flow_pend ? flow_byte : mem_q;
  assign last       = flow_pend ? flow_last : char_last;

`ifndef SYNTHESIS
  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(char_pend && flow_pend))
    else $error("character and flow byte presented together");
  a_no_empty_read: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> !stat.empty)
    else $error("read from empty ring");
  a_no_full_write: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> !stat.full)
    else $error("write into full ring");
  a_no_flow_during_read: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> !cmd.flow_emit)
    else $error("flow byte issued during drain read");
  a_depth_bounds: assert property (@(posedge clk) disable iff (rst)
    !(cmd.depth_inc && stat.depth_max) && !(cmd.depth_dec && stat.depth_zero))
    else $error("pause nesting counter wrapped");
`endif

endmodule

// ===== rtl/serial_rx_fifo_with_xon_xoff_unit.sv =====
// Top level of the serial receive ring buffer with XON/XOFF flow control.
`timescale 1ns / 1ps

//  channel   direction  handshake                 payload
//  command   in         start && !busy            kind, rx_byte, rx_status
//  result    out        out_strobe (one cycle)    out_kind, out_byte, last
//  config    in         APB write, pready = 1     link_connected, flush_when_full,
//                                                 pause_during_drain at 0x0/0x4/0x8
//
// A store, pause or resume transaction completes without raising busy.
// A drain holds busy while it reads out every buffered byte, and also while an XON
// closes it; results appear in the cycle after the controller issues them, registered.
// A flush on a full ring is a drain followed by the store in its last cycle.
// Synchronous reset empties the ring, zeroes the pause count, state and config registers.
// The result receiver cannot stall; one result leaves per strobe.

module serial_rx_fifo_with_xon_xoff_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [7:0]  rx_byte,
  input  logic [1:0]  rx_status,
  output logic        out_strobe,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import srxf_pkg::*;

  logic  link_connected, flush_when_full, pause_during_drain;
  logic  cfg_wr;
  cmd_t  cmd;
  stat_t stat;

  // Configuration registers; word index from paddr[3:2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_connected     <= 1'b0;
      flush_when_full    <= 1'b0;
      pause_during_drain <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LINK:  link_connected     <= pwdata[0];
        REG_FLUSH: flush_when_full    <= pwdata[0];
        REG_PAUSE: pause_during_drain <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LINK:  prdata = {31'd0, link_connected};
      REG_FLUSH: prdata = {31'd0, flush_when_full};
      REG_PAUSE: prdata = {31'd0, pause_during_drain};
      default:   prdata = '0;
    endcase
  end

  srxf_ctrl u_ctrl (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .kind               (kind),
    .rx_status          (rx_status),
    .link_connected     (link_connected),
    .flush_when_full    (flush_when_full),
    .pause_during_drain (pause_during_drain),
    .stat               (stat),
    .cmd                (cmd),
    .busy               (busy)
  );

  srxf_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .rx_byte    (rx_byte),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .last       (last)
  );

endmodule
